// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker.
// Each macro takes a label, the clock, the active-low reset, a condition
// and the property that must follow from it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the condition.
`define PLPN_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("plpn assertion failed");

// The consequent must hold in the cycle after the condition.
`define PLPN_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("plpn assertion failed");

`endif

// ===== rtl/core/plpn_pkg.sv =====
package plpn_pkg;

  localparam int unsigned VAL_BITS            = 32;
  localparam int unsigned FRAC_BITS           = 16;
  localparam int unsigned IDX_BITS            = 12;
  localparam int unsigned COUNT_BITS          = 7;
  localparam int unsigned TOL_BITS            = 16;
  localparam int unsigned CFG_IDX_BITS        = 2;
  localparam int unsigned CFG_DATA_BITS       = TOL_BITS;
  localparam int unsigned MAX_ENTRIES_DEFAULT = 4096;
  localparam int unsigned PROD_BITS           = 2 * VAL_BITS;

  // Step counts of the shared restoring divider.
  localparam int unsigned MOD_STEPS = IDX_BITS;
  localparam int unsigned DIV_STEPS = VAL_BITS;
  localparam int unsigned CNT_BITS  = $clog2(DIV_STEPS);

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd6554;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic KIND_BETA = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_TOLERANCE    = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_ISSUE,
    OP_RD_RESULT,
    OP_BAD_READ,
    OP_MUL_BD,
    OP_MOD_LOAD,
    OP_QUO_LOAD,
    OP_DIV_STEP,
    OP_STORE,
    OP_MUL_BM,
    OP_UP_LOAD,
    OP_UP_TAKE,
    OP_MUL_EB,
    OP_LO_LOAD,
    OP_REPORT
  } dp_op_e;

  typedef struct packed {
    logic                func;
    logic [IDX_BITS-1:0] entry_index;
    logic [VAL_BITS-1:0] coefficient;
    logic [VAL_BITS-1:0] row_bound;
    logic [VAL_BITS-1:0] column_weight;
  } req_t;

  typedef struct packed {
    logic                kind;
    logic [VAL_BITS-1:0] value;
    logic                flagged;
  } rsp_t;

  typedef struct packed {
    logic   latch;
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic req_read;
    logic in_range;
    logic is_last;
  } sts_t;

endpackage

// ===== rtl/core/plpn_ram.sv =====
module plpn_ram #(
  parameter int unsigned WIDTH = plpn_pkg::VAL_BITS,
  parameter int unsigned DEPTH = plpn_pkg::MAX_ENTRIES_DEFAULT,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/plpn_ctrl.sv =====
module plpn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  plpn_pkg::sts_t sts_i,
  output plpn_pkg::cmd_t cmd_o,
  output logic          busy
);
  import plpn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_TAKE,
    S_RD_BAD,
    S_MUL_BD,
    S_MOD_LOAD,
    S_MOD_RUN,
    S_QUO_LOAD,
    S_QUO_RUN,
    S_STORE,
    S_MUL_BM,
    S_UP_LOAD,
    S_UP_RUN,
    S_UP_TAKE,
    S_MUL_EB,
    S_LO_LOAD,
    S_LO_RUN,
    S_REPORT
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  dp_op_e              op_q;
  logic                busy_q;
  logic                accept;

  // Datapath operation carried out while the sequencer sits in a state.
  function automatic dp_op_e op_for(state_e s);
    dp_op_e op;
    op = OP_NONE;
    unique case (s)
      S_IDLE:     op = OP_NONE;
      S_RD_ISSUE: op = OP_RD_ISSUE;
      S_RD_TAKE:  op = OP_RD_RESULT;
      S_RD_BAD:   op = OP_BAD_READ;
      S_MUL_BD:   op = OP_MUL_BD;
      S_MOD_LOAD: op = OP_MOD_LOAD;
      S_MOD_RUN:  op = OP_DIV_STEP;
      S_QUO_LOAD: op = OP_QUO_LOAD;
      S_QUO_RUN:  op = OP_DIV_STEP;
      S_STORE:    op = OP_STORE;
      S_MUL_BM:   op = OP_MUL_BM;
      S_UP_LOAD:  op = OP_UP_LOAD;
      S_UP_RUN:   op = OP_DIV_STEP;
      S_UP_TAKE:  op = OP_UP_TAKE;
      S_MUL_EB:   op = OP_MUL_EB;
      S_LO_LOAD:  op = OP_LO_LOAD;
      S_LO_RUN:   op = OP_DIV_STEP;
      S_REPORT:   op = OP_REPORT;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

  assign accept = start && !busy_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.req_read) begin
            state_d = sts_i.in_range ? S_RD_ISSUE : S_RD_BAD;
          end else if (sts_i.in_range) begin
            state_d = S_MUL_BD;
          end
        end
      end
      S_RD_ISSUE: state_d = S_RD_TAKE;
      S_RD_TAKE:  state_d = S_IDLE;
      S_RD_BAD:   state_d = S_IDLE;
      S_MUL_BD:   state_d = S_MOD_LOAD;
      S_MOD_LOAD: begin
        state_d = S_MOD_RUN;
        cnt_d   = CNT_BITS'(MOD_STEPS - 1);
      end
      S_MOD_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_QUO_LOAD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_QUO_LOAD: begin
        state_d = S_QUO_RUN;
        cnt_d   = CNT_BITS'(DIV_STEPS - 1);
      end
      S_QUO_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_STORE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_STORE:    state_d = sts_i.is_last ? S_MUL_BM : S_IDLE;
      S_MUL_BM:   state_d = S_UP_LOAD;
      S_UP_LOAD: begin
        state_d = S_UP_RUN;
        cnt_d   = CNT_BITS'(DIV_STEPS - 1);
      end
      S_UP_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_UP_TAKE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_UP_TAKE:  state_d = S_MUL_EB;
      S_MUL_EB:   state_d = S_LO_LOAD;
      S_LO_LOAD: begin
        state_d = S_LO_RUN;
        cnt_d   = CNT_BITS'(DIV_STEPS - 1);
      end
      S_LO_RUN: begin
        if (cnt_q == '0) begin
          state_d = S_REPORT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_REPORT:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      op_q    <= OP_NONE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      op_q    <= op_for(state_d);
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign cmd_o.latch = accept;
  assign cmd_o.op    = op_q;
  assign busy        = busy_q;

endmodule

// ===== rtl/core/plpn_dpath.sv =====
module plpn_dpath #(
  parameter int unsigned MAX_ENTRIES = plpn_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  plpn_pkg::req_t                      req_i,
  input  logic                                cfg_we_i,
  input  logic [plpn_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [plpn_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  plpn_pkg::cmd_t                      cmd_i,
  output plpn_pkg::sts_t                      sts_o,
  output logic                                done_o,
  output plpn_pkg::rsp_t                      rsp_o
);
  import plpn_pkg::*;

  localparam int unsigned AddrBits   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned TotalBits  = 2 * COUNT_BITS;
  localparam logic [16:0] EntryLimit = 17'(MAX_ENTRIES);

  // Configuration registers.
  logic [COUNT_BITS-1:0] rows_q, cols_q;
  logic [TOL_BITS-1:0]   tol_q;
  logic [COUNT_BITS-1:0] rows_eff, cols_eff;
  logic [TotalBits-1:0]  total;

  // Request held for the length of one operation.
  logic [IDX_BITS-1:0] idx_q;
  logic [VAL_BITS-1:0] coef_q, bound_q, weight_q;

  // Multiplier and divider.
  logic [VAL_BITS-1:0]  mul_a, mul_b;
  logic [PROD_BITS-1:0] prod_q;
  logic [PROD_BITS-1:0] rem_q, dvs_q;
  logic [VAL_BITS-1:0]  sh_q;
  logic [PROD_BITS:0]   trial, diff;
  logic                 take;

  // Per-load and per-matrix flags.
  logic row_end_q, quo_sat_q, up_sat_q;

  // Running matrix state.
  logic [VAL_BITS-1:0] row_max_q, least_q, upper_q, lower_q;
  logic                sat_seen_q;
  logic [VAL_BITS-1:0] q_store, new_max;

  // Memory and result.
  logic [15:0]          idx_wide;
  logic [AddrBits-1:0]  addr;
  logic [VAL_BITS-1:0]  rdata, clamped;
  logic                 done_q;
  rsp_t                 rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= COUNT_BITS'(1);
      cols_q <= COUNT_BITS'(1);
      tol_q  <= TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:    rows_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_COLUMN_COUNT: cols_q <= cfg_data_i[COUNT_BITS-1:0];
        CFG_TOLERANCE:    tol_q  <= cfg_data_i[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A zero count behaves as one.
  assign rows_eff = (rows_q == '0) ? COUNT_BITS'(1) : rows_q;
  assign cols_eff = (cols_q == '0) ? COUNT_BITS'(1) : cols_q;
  assign total    = TotalBits'(rows_eff) * TotalBits'(cols_eff);

  assign sts_o.req_read = (req_i.func == FUNC_READ);
  assign sts_o.in_range = (TotalBits'(req_i.entry_index) < total) &&
                          (17'(req_i.entry_index) < EntryLimit);
  assign sts_o.is_last  = (TotalBits'(idx_q) == total - TotalBits'(1));

  always_comb begin
    mul_a = bound_q;
    mul_b = weight_q;
    unique case (cmd_i.op)
      OP_MUL_BM: begin
        mul_a = least_q;
        mul_b = VAL_BITS'(rows_eff);
      end
      OP_MUL_EB: begin
        mul_a = VAL_BITS'(tol_q);
        mul_b = least_q;
      end
      default: ;
    endcase
  end

  // One restoring step: shift the next dividend bit into the remainder.
  assign trial = {rem_q, sh_q[VAL_BITS-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      idx_q    <= req_i.entry_index;
      coef_q   <= req_i.coefficient;
      bound_q  <= req_i.row_bound;
      weight_q <= req_i.column_weight;
    end
    unique case (cmd_i.op)
      OP_MUL_BD, OP_MUL_BM, OP_MUL_EB: begin
        prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
      end
      OP_MOD_LOAD: begin
        rem_q <= '0;
        sh_q  <= {idx_q, (VAL_BITS - IDX_BITS)'(0)};
        dvs_q <= PROD_BITS'(cols_eff);
      end
      OP_QUO_LOAD: begin
        // The remainder of the column pass is the column of this entry.
        row_end_q <= (rem_q == PROD_BITS'(cols_eff - COUNT_BITS'(1)));
        // The quotient fits only when the coefficient is below the divisor.
        quo_sat_q <= (prod_q == '0) || (PROD_BITS'(coef_q) >= prod_q);
        rem_q     <= PROD_BITS'(coef_q);
        sh_q      <= '0;
        dvs_q     <= prod_q;
      end
      OP_DIV_STEP: begin
        rem_q <= take ? diff[PROD_BITS-1:0] : trial[PROD_BITS-1:0];
        sh_q  <= {sh_q[VAL_BITS-2:0], take};
      end
      OP_UP_LOAD: begin
        // beta*m*2^16/eps is computed as (beta*m)*2^32/(eps*2^16).
        up_sat_q <= (tol_q == '0) ||
                    (prod_q >= PROD_BITS'({tol_q, {FRAC_BITS{1'b0}}}));
        rem_q    <= prod_q;
        sh_q     <= '0;
        dvs_q    <= PROD_BITS'({tol_q, {FRAC_BITS{1'b0}}});
      end
      OP_LO_LOAD: begin
        rem_q <= '0;
        sh_q  <= prod_q[FRAC_BITS +: VAL_BITS];
        dvs_q <= PROD_BITS'(rows_eff);
      end
      default: ;
    endcase
  end

  assign q_store = quo_sat_q ? '1 : sh_q;
  assign new_max = (q_store > row_max_q) ? q_store : row_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_max_q  <= '0;
      least_q    <= '1;
      upper_q    <= '1;
      lower_q    <= '0;
      sat_seen_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_STORE: begin
          sat_seen_q <= sat_seen_q | quo_sat_q;
          if (row_end_q) begin
            least_q   <= (new_max < least_q) ? new_max : least_q;
            row_max_q <= '0;
          end else begin
            row_max_q <= new_max;
          end
        end
        OP_UP_TAKE: begin
          upper_q <= up_sat_q ? '1 : sh_q;
        end
        OP_REPORT: begin
          lower_q    <= sh_q;
          least_q    <= '1;
          sat_seen_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign idx_wide = 16'(idx_q);
  assign addr     = idx_wide[AddrBits-1:0];

  plpn_ram #(
    .WIDTH (VAL_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_STORE),
    .waddr_i (addr),
    .wdata_i (q_store),
    .re_i    (cmd_i.op == OP_RD_ISSUE),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign clamped = (rdata > upper_q) ? upper_q :
                   (rdata < lower_q) ? '0 : rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_RD_RESULT) || (cmd_i.op == OP_BAD_READ) ||
                (cmd_i.op == OP_REPORT);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_RD_RESULT: begin
        rsp_q.kind    <= KIND_READ;
        rsp_q.value   <= clamped;
        rsp_q.flagged <= 1'b0;
      end
      OP_BAD_READ: begin
        rsp_q.kind    <= KIND_READ;
        rsp_q.value   <= '0;
        rsp_q.flagged <= 1'b1;
      end
      OP_REPORT: begin
        rsp_q.kind    <= KIND_BETA;
        rsp_q.value   <= least_q;
        rsp_q.flagged <= sat_seen_q | up_sat_q;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/core/packing_lp_coefficient_normalizer_unit.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_i (func, index, c, b, d)
// result    out        done_o strobe, one cycle  rsp_o (kind, value, flagged)
// config    in         cfg_we_i, no wait         cfg_index_i, cfg_data_i
//
// A read fetches the entry from the RAM, then registers it clamped to the
// read limits; an out-of-range read skips the RAM. A load holds busy for a
// multiply, 12 divider steps for the column, 32 for the quotient, the set-up
// of both divider passes and the store. The last load of a matrix adds two
// 32-step passes for the limits and reports beta as busy falls. Reset
// restores the default configuration and clears the sequencer and matrix
// state. The receiver cannot stall: a result is shown for exactly one cycle.
module packing_lp_coefficient_normalizer_unit #(
  parameter int unsigned MAX_ENTRIES = plpn_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  plpn_pkg::req_t                     req_i,
  output logic                               done_o,
  output plpn_pkg::rsp_t                     rsp_o,
  input  logic                               cfg_we_i,
  input  logic [plpn_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [plpn_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import plpn_pkg::*;

  // The controller decides the sequence of datapath operations for each
  // request; the datapath reports back whether the request is inside the
  // matrix and whether a load hits the last entry.
  cmd_t cmd;
  sts_t sts;

  plpn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // The datapath holds the configuration, one 32x32 multiplier, the shared
  // restoring divider, the running row maximum and beta, the read limits,
  // the coefficient store and the registered result.
  plpn_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== rtl/core/plpn_checker.sv =====
`include "assert_macros.svh"

module plpn_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input plpn_pkg::req_t req_i,
  input logic           done_o
);
  import plpn_pkg::*;

  // Every result comes out of a busy period.
  `PLPN_ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  // One result per request: never two strobes back to back.
  `PLPN_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // An accepted read always starts work.
  `PLPN_ASSERT_NXT(a_read_goes_busy, clk_i, rst_ni, start && !busy && req_i.func == FUNC_READ, busy)
  // A load never produces a result in the following cycle.
  `PLPN_ASSERT_NXT(a_load_no_fast_result, clk_i, rst_ni, start && !busy && req_i.func == FUNC_LOAD, !done_o)

endmodule

bind packing_lp_coefficient_normalizer_unit plpn_checker u_plpn_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o)
);
